// ===== design/sclc_pkg.sv =====
// Package for the serial command lock controller: opcodes, pending-operation
// codes, configuration register indexes, reset values and field widths.
// No dependencies.
package sclc_pkg;

  localparam int CODE_LEN = 4;
  localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

  localparam int BYTE_W   = 8;
  localparam int LIMIT_W  = 3;
  localparam int TBASE_W  = 16;
  localparam int TSTEP_W  = 10;
  localparam int PSTEP_W  = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DEC_W    = BYTE_W + TSTEP_W;
  localparam int CLAMP_W  = 4;
  localparam int PVAL_W   = 14;
  localparam int ERR_W    = 3;

  localparam logic [ERR_W-1:0]   ERR_MAX       = 3'd7;
  localparam logic [CLAMP_W-1:0] PERIOD_MIN    = 4'd1;
  localparam logic [CLAMP_W-1:0] PERIOD_MAX    = 4'd10;

  localparam logic [LIMIT_W-1:0] LIMIT_RST     = 3'd3;
  localparam logic [TBASE_W-1:0] TBASE_RST     = 16'd1200;
  localparam logic [TSTEP_W-1:0] TSTEP_RST     = 10'd100;
  localparam logic [PSTEP_W-1:0] PSTEP_RST     = 10'd500;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [BYTE_W-1:0] {
    CMD_LIGHT_ON  = 8'hA1,
    CMD_LIGHT_OFF = 8'hA2,
    CMD_CHANGE    = 8'hA3,
    CMD_ENTER     = 8'hA4,
    CMD_PERIOD    = 8'hA5,
    CMD_SPEED     = 8'hA6,
    CMD_SOUND     = 8'hA7,
    CMD_END       = 8'hFF
  } cmd_t;

  typedef enum logic [2:0] {
    OP_IDLE   = 3'd0,
    OP_CHANGE = 3'd1,
    OP_ENTER  = 3'd2,
    OP_SPEED  = 3'd3,
    OP_PERIOD = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCKOUT_LIMIT = 2'd0,
    REG_TIMEOUT_BASE  = 2'd1,
    REG_TIMEOUT_STEP  = 2'd2,
    REG_PERIOD_STEP   = 2'd3
  } cfg_reg_t;

endpackage

// ===== design/serial_command_lock_controller_core.sv =====
// Serial command lock controller, top level: input register, command decode
// and state update, result register. Depends on sclc_pkg.
//
// Usage: the block takes one command byte per cycle while the output is not
// stalled, and returns exactly one result per byte. A byte is captured in the
// input register, then decoded and applied to the lock state as it moves into
// the result register, where the result is offered until it is taken; while
// the output is stalled the byte waits in the input register. The lock state
// feeds back on itself through that one decode stage, which sets the rate at
// one byte per cycle when the output is not stalled. The input register and
// the result register each hold one request, so while a finished result waits
// to be taken one more byte is accepted before the input stalls. Configuration
// writes take effect at once and are meant to be made while the block is idle.
module serial_command_lock_controller_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sclc_pkg::BYTE_W-1:0]          in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_armed,
  output logic                                 out_alarm_on,
  output logic                                 out_inner_light,
  output logic                                 out_sound_sel,
  output logic                                 out_timeout_write,
  output logic [sclc_pkg::TBASE_W-1:0]         out_timeout_value,
  output logic                                 out_period_write,
  output logic [sclc_pkg::PVAL_W-1:0]          out_period_value,
  output logic [sclc_pkg::ERR_W-1:0]           out_error_count,
  input  logic                                 cfg_wr_en,
  input  logic [sclc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sclc_pkg::CFG_W-1:0]           cfg_wr_data
);
  import sclc_pkg::*;

  // configuration
  logic [LIMIT_W-1:0] limit_r;
  logic [TBASE_W-1:0] tbase_r;
  logic [TSTEP_W-1:0] tstep_r;
  logic [PSTEP_W-1:0] pstep_r;

  // input stage
  logic  s1_valid_r;
  byte_t s1_byte_r;
  logic  proc;

  // lock state
  byte_t            stored_r [CODE_LEN];
  byte_t            stored_nxt [CODE_LEN];
  byte_t            buf_r [CODE_LEN];
  byte_t            buf_nxt [CODE_LEN];
  logic [IDX_W-1:0] idx_r, idx_nxt;
  op_t              pend_r, pend_nxt;
  logic             verified_r, verified_nxt;
  logic [ERR_W-1:0] wrong_r, wrong_nxt;
  logic             armed_r, armed_nxt;
  logic             siren_r, siren_nxt;
  logic             light_r, light_nxt;
  logic             sound_r, sound_nxt;

  // result stage
  logic               out_valid_r;
  logic               twr_r, twr_nxt;
  logic [TBASE_W-1:0] tval_r, tval_nxt;
  logic               pwr_r, pwr_nxt;
  logic [PVAL_W-1:0]  pval_r, pval_nxt;

  // datapath helpers
  logic [DEC_W-1:0]   dec;
  logic [CLAMP_W-1:0] clamp;
  logic [PVAL_W-1:0]  pprod;
  logic               match_cur, match_new;
  logic               is_end;
  logic [IDX_W-1:0]   idx_inc;
  logic [ERR_W-1:0]   wrong_sat;

  assign proc     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || proc;
  assign is_end   = (s1_byte_r == CMD_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      tbase_r <= TBASE_RST;
      tstep_r <= TSTEP_RST;
      pstep_r <= PSTEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOCKOUT_LIMIT: limit_r <= cfg_wr_data[LIMIT_W-1:0];
        REG_TIMEOUT_BASE:  tbase_r <= cfg_wr_data[TBASE_W-1:0];
        REG_TIMEOUT_STEP:  tstep_r <= cfg_wr_data[TSTEP_W-1:0];
        REG_PERIOD_STEP:   pstep_r <= cfg_wr_data[PSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Arithmetic for speed and period arguments
  always_comb begin
    dec = DEC_W'(s1_byte_r) * DEC_W'(tstep_r);
    if (s1_byte_r < BYTE_W'(PERIOD_MIN)) begin
      clamp = PERIOD_MIN;
    end else if (s1_byte_r > BYTE_W'(PERIOD_MAX)) begin
      clamp = PERIOD_MAX;
    end else begin
      clamp = s1_byte_r[CLAMP_W-1:0];
    end
    pprod = PVAL_W'(clamp) * PVAL_W'(pstep_r);
  end

  // Digit write into the buffer and code compares
  always_comb begin
    idx_inc = (idx_r == IDX_W'(CODE_LEN - 1)) ? '0 : idx_r + 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (!is_end && (pend_r == OP_CHANGE || pend_r == OP_ENTER)) begin
      buf_nxt[idx_r] = s1_byte_r;
    end
    match_cur = 1'b1;
    match_new = 1'b1;
    for (int i = 0; i < CODE_LEN; i++) begin
      if (stored_r[i] != buf_r[i])   match_cur = 1'b0;
      if (stored_r[i] != buf_nxt[i]) match_new = 1'b0;
    end
    wrong_sat = (wrong_r < ERR_MAX) ? wrong_r + 1'b1 : wrong_r;
  end

  // Next state of the lock
  always_comb begin
    for (int i = 0; i < CODE_LEN; i++) begin
      stored_nxt[i] = stored_r[i];
    end
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    verified_nxt = verified_r;
    wrong_nxt    = wrong_r;
    armed_nxt    = armed_r;
    siren_nxt    = siren_r;
    light_nxt    = light_r;
    sound_nxt    = sound_r;
    twr_nxt      = 1'b0;
    tval_nxt     = '0;
    pwr_nxt      = 1'b0;
    pval_nxt     = '0;
    if (is_end) begin
      idx_nxt = '0;
      case (pend_r)
        OP_CHANGE: begin
          if (verified_r) begin
            for (int i = 0; i < CODE_LEN; i++) begin
              stored_nxt[i] = buf_r[i];
            end
          end
          verified_nxt = 1'b0;
          pend_nxt     = OP_IDLE;
        end
        OP_ENTER: begin
          pend_nxt = OP_IDLE;
          if (match_cur) begin
            armed_nxt = !armed_r;
            wrong_nxt = '0;
            siren_nxt = 1'b0;
          end else begin
            wrong_nxt = wrong_sat;
            if (wrong_sat > ERR_W'(limit_r)) begin
              siren_nxt = 1'b1;
              armed_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (pend_r)
        OP_CHANGE: begin
          idx_nxt = idx_inc;
          // a wrap closes one full code: check it against the stored one
          if (idx_inc == '0 && match_new) verified_nxt = 1'b1;
        end
        OP_ENTER: begin
          idx_nxt = idx_inc;
        end
        OP_SPEED: begin
          twr_nxt  = 1'b1;
          tval_nxt = (dec >= DEC_W'(tbase_r)) ? '0 : tbase_r - dec[TBASE_W-1:0];
          pend_nxt = OP_IDLE;
        end
        OP_PERIOD: begin
          pwr_nxt  = 1'b1;
          pval_nxt = pprod;
          pend_nxt = OP_IDLE;
        end
        default: begin
          pend_nxt = OP_IDLE;
          case (s1_byte_r)
            CMD_LIGHT_ON:  light_nxt = 1'b1;
            CMD_LIGHT_OFF: light_nxt = 1'b0;
            CMD_CHANGE: begin
              idx_nxt  = '0;
              pend_nxt = OP_CHANGE;
            end
            CMD_ENTER: begin
              idx_nxt  = '0;
              pend_nxt = OP_ENTER;
            end
            CMD_PERIOD:    pend_nxt  = OP_PERIOD;
            CMD_SPEED:     pend_nxt  = OP_SPEED;
            CMD_SOUND:     sound_nxt = !sound_r;
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CODE_LEN; i++) begin
        stored_r[i] <= BYTE_W'(i + 1);
        buf_r[i]    <= '0;
      end
      idx_r      <= '0;
      pend_r     <= OP_IDLE;
      verified_r <= 1'b0;
      wrong_r    <= '0;
      armed_r    <= 1'b0;
      siren_r    <= 1'b0;
      light_r    <= 1'b0;
      sound_r    <= 1'b0;
    end else if (proc) begin
      for (int i = 0; i < CODE_LEN; i++) begin
        stored_r[i] <= stored_nxt[i];
        buf_r[i]    <= buf_nxt[i];
      end
      idx_r      <= idx_nxt;
      pend_r     <= pend_nxt;
      verified_r <= verified_nxt;
      wrong_r    <= wrong_nxt;
      armed_r    <= armed_nxt;
      siren_r    <= siren_nxt;
      light_r    <= light_nxt;
      sound_r    <= sound_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      twr_r  <= twr_nxt;
      tval_r <= tval_nxt;
      pwr_r  <= pwr_nxt;
      pval_r <= pval_nxt;
    end
  end

  // Flag outputs come straight from the state, which only moves with a result
  assign out_valid         = out_valid_r;
  assign out_armed         = armed_r;
  assign out_alarm_on      = siren_r;
  assign out_inner_light   = light_r;
  assign out_sound_sel     = sound_r;
  assign out_timeout_write = twr_r;
  assign out_timeout_value = tval_r;
  assign out_period_write  = pwr_r;
  assign out_period_value  = pval_r;
  assign out_error_count   = wrong_r;

`ifndef NO_ASSERTIONS
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_timeout_write && out_period_write))
    else $error("timeout and period written by one request");

  a_tval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_timeout_write) |-> (out_timeout_value == '0))
    else $error("timeout value nonzero without write");

  a_arg_done: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !is_end && (pend_r == OP_SPEED || pend_r == OP_PERIOD))
    |=> (pend_r == OP_IDLE))
    else $error("argument byte did not return to idle");

  a_verified_change: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != OP_CHANGE) |-> !verified_r)
    else $error("old code flag set outside a code change");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(armed_r) && $stable(wrong_r))
    else $error("lock state moved under a stalled result");
`endif

endmodule
